// ===== sv/ocps_pkg.sv =====
// ----------------------------------------------------------------------------
// ocps_pkg
// Shared sizes for the odd-only prime sieve counter: mark store depth and
// the widths of the limit, count and working registers.
// ----------------------------------------------------------------------------
package ocps_pkg;

   localparam int MARK_DEPTH = 32768;
   localparam int IDX_W      = $clog2(MARK_DEPTH);

   localparam int LIMIT_W    = 17;
   localparam int COUNT_W    = 13;
   localparam int PRIME_W    = 17;

   // Entry counters must hold the store depth itself and any index that a
   // limit of LIMIT_W bits can reach.
   localparam int ENT_W      = (LIMIT_W > IDX_W + 1) ? LIMIT_W : IDX_W + 1;
   localparam int SQ_W       = 2 * PRIME_W;
   localparam int TALLY_W    = IDX_W + 1;

endpackage

// ===== sv/ocps_ram.sv =====
// ----------------------------------------------------------------------------
// ocps_ram
// Generic single-port RAM with one write or read per cycle and a registered
// read port.
// ----------------------------------------------------------------------------
module ocps_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// ===== sv/odd_only_prime_sieve_count_unit.sv =====
// ----------------------------------------------------------------------------
// odd_only_prime_sieve_count_unit
// Counts the primes up to a limit with an odd-only Sieve of Eratosthenes over
// a one-bit mark store, walked by a small sequencer.
//
//   channel   ports                                 transfer
//   request   req_start, req_limit_n, busy          req_start high, busy low
//   response  rsp_strobe, rsp_prime_count           rsp_strobe high, one cycle
//
// With E = min((n-1)/2, MARK_DEPTH) store entries in use, one request clears
// the E entries, writes the marks of each sieving prime, scans the store for
// the next prime and reads the E entries back to count them. The single port
// of the mark RAM, one access per cycle, paces each of these passes.
// The store is cleared at the start of each request; reset needs no pass. busy
// falls in the cycle that the result is shown, and the receiver cannot stall.
// ----------------------------------------------------------------------------
module odd_only_prime_sieve_count_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_start,
   input  logic [ocps_pkg::LIMIT_W-1:0] req_limit_n,
   output logic                        busy,
   output logic                        rsp_strobe,
   output logic [ocps_pkg::COUNT_W-1:0] rsp_prime_count
);

   import ocps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SQUARE,
      ST_CHECK,
      ST_MARK,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_COUNT
   } state_type;

   state_type            state_ff, state_in;
   logic [LIMIT_W-1:0]   n_ff, n_in;
   logic [ENT_W-1:0]     entries_ff, entries_in;
   logic [PRIME_W-1:0]   p_ff, p_in;
   logic [ENT_W-1:0]     idx_ff, idx_in;
   logic [ENT_W-1:0]     walk_ff, walk_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [TALLY_W-1:0]   tally_ff, tally_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 strobe_ff, strobe_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_addr;
   logic                 ram_wdata;
   logic                 ram_rdata;

   logic [ENT_W-1:0]     half_n;
   logic [ENT_W:0]       odd_value;
   logic [ENT_W-1:0]     idx_next;
   logic [SQ_W-1:0]      square;

   assign square = SQ_W'(p_ff) * SQ_W'(p_ff);

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      entries_in = entries_ff;
      p_in       = p_ff;
      idx_in     = idx_ff;
      walk_in    = walk_ff;
      sq_in      = sq_ff;
      tally_in   = tally_ff;
      rd_pend_in = 1'b0;
      strobe_in  = 1'b0;
      count_in   = count_ff;
      ram_we     = 1'b0;
      ram_addr   = walk_ff[IDX_W-1:0];
      ram_wdata  = 1'b0;

      half_n    = (ENT_W'(req_limit_n) - ENT_W'(1)) >> 1;
      idx_next  = idx_ff + ENT_W'(1);
      odd_value = {idx_ff, 1'b1} + (ENT_W + 1)'(2);

      case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               n_in     = req_limit_n;
               p_in     = PRIME_W'(3);
               idx_in   = '0;
               walk_in  = '0;
               tally_in = '0;
               if (req_limit_n < LIMIT_W'(2)) begin
                  entries_in = '0;
               end else if (half_n > ENT_W'(MARK_DEPTH)) begin
                  entries_in = ENT_W'(MARK_DEPTH);
               end else begin
                  entries_in = half_n;
               end
               state_in = ST_CLEAR;
            end
         end

         ST_CLEAR: begin
            if (walk_ff < entries_ff) begin
               ram_we    = 1'b1;
               ram_wdata = 1'b0;
               walk_in   = walk_ff + ENT_W'(1);
            end else begin
               state_in = ST_SQUARE;
            end
         end

         ST_SQUARE: begin
            sq_in    = square;
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (sq_ff > SQ_W'(n_ff)) begin
               walk_in  = '0;
               state_in = ST_COUNT;
            end else begin
               // First odd multiple to strike is p*p, at entry (p*p-3)/2.
               walk_in  = ENT_W'((sq_ff - SQ_W'(3)) >> 1);
               state_in = ST_MARK;
            end
         end

         ST_MARK: begin
            if (walk_ff < entries_ff) begin
               ram_we    = 1'b1;
               ram_wdata = 1'b1;
               walk_in   = walk_ff + ENT_W'(p_ff);
            end else begin
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (idx_next < entries_ff) begin
               idx_in   = idx_next;
               ram_addr = idx_next[IDX_W-1:0];
               state_in = ST_SCAN_WAIT;
            end else begin
               // The search ran off the end of the store: sieving is over.
               walk_in  = '0;
               state_in = ST_COUNT;
            end
         end

         ST_SCAN_WAIT: begin
            if (!ram_rdata) begin
               p_in     = PRIME_W'(odd_value);
               state_in = ST_SQUARE;
            end else begin
               state_in = ST_SCAN;
            end
         end

         ST_COUNT: begin
            if (rd_pend_ff && !ram_rdata) begin
               tally_in = tally_ff + TALLY_W'(1);
            end
            if (walk_ff < entries_ff) begin
               rd_pend_in = 1'b1;
               walk_in    = walk_ff + ENT_W'(1);
            end else if (!rd_pend_ff) begin
               strobe_in = 1'b1;
               if (n_ff < LIMIT_W'(2)) begin
                  count_in = '0;
               end else begin
                  // One more for the prime two, which the store leaves out.
                  count_in = COUNT_W'(tally_ff + TALLY_W'(1));
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         p_ff       <= PRIME_W'(3);
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p_ff       <= p_in;
         idx_ff     <= idx_in;
         rd_pend_ff <= rd_pend_in;
         strobe_ff  <= strobe_in;
      end
      n_ff       <= n_in;
      entries_ff <= entries_in;
      walk_ff    <= walk_in;
      sq_ff      <= sq_in;
      tally_ff   <= tally_in;
      count_ff   <= count_in;
   end

   ocps_ram #(
      .WIDTH (1),
      .DEPTH (MARK_DEPTH)
   ) u_marks (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_prime_count = count_ff;

endmodule
